// ===== rtl/lsch_pkg.sv =====
// ----------------------------------------------------------------------------
// Lottery scheduler package
// Shared sizes, function and status codes, and controller/datapath bundles.
// ----------------------------------------------------------------------------
package lsch_pkg;

  localparam int NumSlots   = 16;
  localparam int SlotW      = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int SlotPortW  = 4;
  localparam int ArrW       = 16;
  localparam int DemW       = 8;
  localparam int RndW       = 16;
  localparam int CntW       = $clog2(RndW);
  localparam int TickW      = 7;
  localparam int TotW       = $clog2(NumSlots * 127 + 1);
  localparam int TotOutW    = 11;
  localparam int ClockW     = 20;
  localparam int QuantW     = 8;

  localparam logic [ClockW-1:0] ClockMax    = {ClockW{1'b1}};
  localparam logic [QuantW-1:0] QuantumDflt = 8'd5;

  // func codes
  localparam logic [1:0] FuncLoad  = 2'd0;
  localparam logic [1:0] FuncStep  = 2'd1;
  localparam logic [1:0] FuncClear = 2'd2;

  // status codes
  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StRan  = 2'd1;
  localparam logic [1:0] StAdv  = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  typedef struct packed {
    logic load;
    logic clear;
    logic nop;
    logic sum_init;
    logic sum_en;
    logic div_init;
    logic div_step;
    logic pick_en;
    logic fin_done;
    logic fin_adv;
    logic fin_run;
  } lsch_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic pending;
    logic total_zero;
    logic found;
    logic div_last;
    logic hit;
  } lsch_stat_t;

endpackage

// ===== rtl/lsch_cfg.sv =====
// ----------------------------------------------------------------------------
// Lottery scheduler register port
// APB-style access to the quantum register.
// ----------------------------------------------------------------------------
module lsch_cfg
  import lsch_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [QuantW-1:0] quantum_o
);

  logic [QuantW-1:0] quantum_q, quantum_d;
  logic              wr_en;

  // register 0 sits at byte address 0; address 4 is outside the map
  assign wr_en = psel && penable && pwrite && !paddr[2];

  always_comb begin
    quantum_d = quantum_q;
    if (wr_en) begin
      quantum_d = pwdata[QuantW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= QuantumDflt;
    end else begin
      quantum_q <= quantum_d;
    end
  end

  assign prdata    = paddr[2] ? 32'd0 : 32'(quantum_q);
  assign pready    = 1'b1;
  assign quantum_o = quantum_q;

endmodule

// ===== rtl/lsch_dp.sv =====
// ----------------------------------------------------------------------------
// Lottery scheduler datapath
// Slot table, clock, ticket accumulators, draw divider and result registers.
// ----------------------------------------------------------------------------
module lsch_dp
  import lsch_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lsch_cmd_t            cmd_i,
  output lsch_stat_t           stat_o,
  input  logic [QuantW-1:0]    quantum_i,
  input  logic [SlotPortW-1:0] slot_i,
  input  logic [ArrW-1:0]      arrival_i,
  input  logic [DemW-1:0]      demand_i,
  input  logic [RndW-1:0]      random_word_i,
  output logic                 result_valid_o,
  output logic [1:0]           status_o,
  output logic [SlotPortW-1:0] winner_o,
  output logic [DemW-1:0]      remaining_o,
  output logic [TickW-1:0]     winner_tickets_o,
  output logic [TotOutW-1:0]   total_tickets_o,
  output logic [ClockW-1:0]    clock_res_o
);

  logic [ArrW-1:0]  arrival_q [NumSlots];
  logic [DemW-1:0]  demand_q  [NumSlots];
  logic [ClockW-1:0] time_q;

  logic [SlotW-1:0] idx_q, win_q;
  logic [TotW-1:0]  total_q, rem_q, acc_q;
  logic             pending_q, found_q;
  logic [ArrW-1:0]  next_q;
  logic [RndW-1:0]  rnd_q;
  logic [CntW-1:0]  cnt_q;
  logic [TickW-1:0] wt_q;

  logic             res_valid_q;
  logic [1:0]       res_status_q;
  logic [SlotPortW-1:0] res_win_q;
  logic [DemW-1:0]  res_rem_q;
  logic [TickW-1:0] res_wt_q;
  logic [TotOutW-1:0] res_tot_q;

  logic [ArrW-1:0]  rd_arr;
  logic [DemW-1:0]  rd_dem;
  logic             ready;
  logic [TickW-1:0] tick;
  logic [TotW-1:0]  acc_n;
  logic [TotW:0]    trial;
  logic             trial_ge;
  logic [TotW-1:0]  rem_n;
  logic [DemW-1:0]  win_dem, run_amt, new_dem;
  logic [QuantW-1:0] q_eff;
  logic [ClockW:0]  time_sum;
  logic [ClockW-1:0] time_run;
  logic             wr_ok;
  logic [SlotW-1:0] wr_idx;
  logic             idx_last;

  always_comb begin
    rd_arr   = arrival_q[idx_q];
    rd_dem   = demand_q[idx_q];
    ready    = (rd_dem != '0) && (ClockW'(rd_arr) <= time_q);
    if (!ready) begin
      tick = '0;
    end else if (rd_dem[DemW-1:1] == '0) begin
      tick = TickW'(1);
    end else begin
      tick = rd_dem[DemW-1:1];
    end
    acc_n    = TotW'(acc_q + TotW'(tick));
    idx_last = (idx_q == SlotW'(NumSlots - 1));

    // one restoring step of random_word mod total
    trial    = {rem_q, rnd_q[RndW-1]};
    trial_ge = (trial >= {1'b0, total_q});
    rem_n    = trial_ge ? TotW'(trial - {1'b0, total_q}) : TotW'(trial);

    win_dem  = demand_q[win_q];
    q_eff    = (quantum_i == '0) ? QuantumDflt : quantum_i;
    run_amt  = (win_dem < q_eff) ? win_dem : q_eff;
    new_dem  = win_dem - run_amt;
    time_sum = {1'b0, time_q} + (ClockW+1)'(run_amt);
    time_run = (time_sum > {1'b0, ClockMax}) ? ClockMax : time_sum[ClockW-1:0];

    wr_ok    = (32'(slot_i) < 32'(NumSlots));
    wr_idx   = SlotW'(slot_i);
  end

  assign stat_o.idx_last   = idx_last;
  assign stat_o.pending    = pending_q;
  assign stat_o.total_zero = (total_q == '0);
  assign stat_o.found      = found_q;
  assign stat_o.div_last   = (cnt_q == CntW'(RndW - 1));
  assign stat_o.hit        = (tick != '0) && (rem_q < acc_n);

  // slot demand and clock
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSlots; i++) begin
        demand_q[i] <= '0;
      end
      time_q <= '0;
    end else begin
      if (cmd_i.load && wr_ok) begin
        demand_q[wr_idx] <= demand_i;
      end
      if (cmd_i.clear) begin
        for (int i = 0; i < NumSlots; i++) begin
          demand_q[i] <= '0;
        end
        time_q <= '0;
      end
      if (cmd_i.fin_adv) begin
        time_q <= ClockW'(next_q);
      end
      if (cmd_i.fin_run) begin
        demand_q[win_q] <= new_dem;
        time_q          <= time_run;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && wr_ok) begin
      arrival_q[wr_idx] <= arrival_i;
    end
  end

  // walk, divider and pick registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_init) begin
      idx_q     <= '0;
      total_q   <= '0;
      pending_q <= 1'b0;
      found_q   <= 1'b0;
      next_q    <= '0;
      rnd_q     <= random_word_i;
    end
    if (cmd_i.sum_en) begin
      idx_q   <= idx_last ? '0 : idx_q + SlotW'(1);
      total_q <= TotW'(total_q + TotW'(tick));
      if (rd_dem != '0) begin
        pending_q <= 1'b1;
        // track the earliest later arrival
        if ((ClockW'(rd_arr) > time_q) && (!found_q || rd_arr < next_q)) begin
          next_q  <= rd_arr;
          found_q <= 1'b1;
        end
      end
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      cnt_q <= '0;
      acc_q <= '0;
      idx_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_n;
      rnd_q <= {rnd_q[RndW-2:0], 1'b0};
      cnt_q <= cnt_q + CntW'(1);
    end
    if (cmd_i.pick_en) begin
      acc_q <= acc_n;
      idx_q <= idx_last ? '0 : idx_q + SlotW'(1);
      win_q <= idx_q;
      wt_q  <= tick;
    end
  end

  // result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.load || cmd_i.clear || cmd_i.nop || cmd_i.fin_done ||
                     cmd_i.fin_adv || cmd_i.fin_run;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_run) begin
      res_status_q <= StRan;
      res_win_q    <= SlotPortW'(win_q);
      res_rem_q    <= new_dem;
      res_wt_q     <= wt_q;
      res_tot_q    <= TotOutW'(total_q);
    end else begin
      if (cmd_i.fin_done) begin
        res_status_q <= StDone;
      end else if (cmd_i.fin_adv) begin
        res_status_q <= StAdv;
      end else begin
        res_status_q <= StOk;
      end
      res_win_q <= '0;
      res_rem_q <= '0;
      res_wt_q  <= '0;
      res_tot_q <= '0;
    end
  end

  assign result_valid_o   = res_valid_q;
  assign status_o         = res_status_q;
  assign winner_o         = res_win_q;
  assign remaining_o      = res_rem_q;
  assign winner_tickets_o = res_wt_q;
  assign total_tickets_o  = res_tot_q;
  assign clock_res_o      = time_q;

endmodule

// ===== rtl/lsch_ctrl.sv =====
// ----------------------------------------------------------------------------
// Lottery scheduler controller
// Sequences the ticket sum, the draw division and the winner search.
// ----------------------------------------------------------------------------
module lsch_ctrl
  import lsch_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] func_i,
  input  lsch_stat_t stat_i,
  output lsch_cmd_t  cmd_o,
  output logic       busy_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StSum    = 3'd1;
  localparam logic [2:0] StDecide = 3'd2;
  localparam logic [2:0] StDiv    = 3'd3;
  localparam logic [2:0] StPick   = 3'd4;
  localparam logic [2:0] StRun    = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          unique case (func_i)
            FuncLoad:  cmd_o.load = 1'b1;
            FuncClear: cmd_o.clear = 1'b1;
            FuncStep: begin
              cmd_o.sum_init = 1'b1;
              state_d        = StSum;
            end
            default:   cmd_o.nop = 1'b1;
          endcase
        end
      end
      StSum: begin
        cmd_o.sum_en = 1'b1;
        if (stat_i.idx_last) begin
          state_d = StDecide;
        end
      end
      StDecide: begin
        if (!stat_i.pending) begin
          cmd_o.fin_done = 1'b1;
          state_d        = StIdle;
        end else if (stat_i.total_zero) begin
          cmd_o.fin_adv  = stat_i.found;
          cmd_o.fin_done = !stat_i.found;
          state_d        = StIdle;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = StPick;
        end
      end
      StPick: begin
        cmd_o.pick_en = 1'b1;
        // the draw is below the total, so a hit comes by the last slot
        if (stat_i.hit || stat_i.idx_last) begin
          state_d = StRun;
        end
      end
      StRun: begin
        cmd_o.fin_run = 1'b1;
        state_d       = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);

endmodule

// ===== rtl/lottery_scheduler.sv =====
// Latency: load, clear and unused func report one cycle after acceptance and
// leave busy low, so such items can be taken every cycle.
// A step sums the tickets over every slot in turn, decides, divides the random word
// by the ticket total, searches the slots for the winner and updates it; with no
// ready slot it ends at the decide state, without the divide and the search.
// Reset (rst_ni low, async) empties all slots, zeroes the clock, sets quantum 5.
module lottery_scheduler
  import lsch_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           func_i,
  input  logic [SlotPortW-1:0] slot_i,
  input  logic [ArrW-1:0]      arrival_i,
  input  logic [DemW-1:0]      demand_i,
  input  logic [RndW-1:0]      random_word_i,
  output logic                 result_valid_o,
  output logic [1:0]           status_o,
  output logic [SlotPortW-1:0] winner_o,
  output logic [DemW-1:0]      remaining_o,
  output logic [TickW-1:0]     winner_tickets_o,
  output logic [TotOutW-1:0]   total_tickets_o,
  output logic [ClockW-1:0]    clock_res_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  lsch_cmd_t         cmd;
  lsch_stat_t        stat;
  logic [QuantW-1:0] quantum;

  lsch_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .quantum_o (quantum)
  );

  lsch_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .func_i  (func_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  lsch_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .quantum_i        (quantum),
    .slot_i           (slot_i),
    .arrival_i        (arrival_i),
    .demand_i         (demand_i),
    .random_word_i    (random_word_i),
    .result_valid_o   (result_valid_o),
    .status_o         (status_o),
    .winner_o         (winner_o),
    .remaining_o      (remaining_o),
    .winner_tickets_o (winner_tickets_o),
    .total_tickets_o  (total_tickets_o),
    .clock_res_o      (clock_res_o)
  );

endmodule

// ===== rtl/lsch_checker.sv =====
// ----------------------------------------------------------------------------
// Lottery scheduler checker
// Port-level properties of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module lsch_checker
  import lsch_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic [1:0]           func_i,
  input logic                 result_valid_o,
  input logic [1:0]           status_o,
  input logic [SlotPortW-1:0] winner_o,
  input logic [DemW-1:0]      remaining_o,
  input logic [TickW-1:0]     winner_tickets_o,
  input logic [TotOutW-1:0]   total_tickets_o,
  input logic [ClockW-1:0]    clock_res_o
);

  // a load item reports status ok in the very next cycle
  a_load_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == FuncLoad) |=> (result_valid_o && status_o == StOk))
    else $error("load item did not report next cycle");

  // a step item holds the block busy while it works
  a_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == FuncStep) |=> (busy && !result_valid_o))
    else $error("step item did not raise busy");

  // only a run result carries winner fields
  a_no_winner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != StRan) |->
      (winner_o == '0 && remaining_o == '0 && winner_tickets_o == '0 &&
       total_tickets_o == '0))
    else $error("winner fields set on a non-run result");

  // a winner always held at least one ticket
  a_winner_tickets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == StRan) |->
      (winner_tickets_o != '0 && total_tickets_o != '0))
    else $error("run result with zero tickets");

  // done leaves the clock where it was
  a_done_clock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == StDone && $past(rst_ni)) |-> $stable(clock_res_o))
    else $error("clock moved on a done result");

endmodule

bind lottery_scheduler lsch_checker u_lsch_checker (.*);
